>>> sv/sacl_pkg.sv
// Shared types and constants for the set-associative cache tag store with LRU ages.
// No dependencies; compile first.
package sacl_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned WAYS_DEF      = 4;
    localparam int unsigned MAX_SETS_DEF  = 64;
    localparam int unsigned AGE_WIDTH_DEF = 16;

    localparam int unsigned OFS_W     = 4;
    localparam int unsigned SETB_W    = 3;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;

    // Widest masked set index: set_bits tops out at 7
    localparam int unsigned SIDX_W = 7;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SET_BITS     = 2'd2;

    localparam logic [DATA_W-1:0] BASE_RST = '0;
    localparam logic [OFS_W-1:0]  OFS_RST  = 4'd6;
    localparam logic [SETB_W-1:0] SETB_RST = 3'd6;

    typedef struct packed {
        logic [DATA_W-1:0] base_address;
        logic [OFS_W-1:0]  offset_bits;
        logic [SETB_W-1:0] set_bits;
    } t_cfg;

endpackage

>>> sv/sacl_ifs.sv
// Valid/ready channel interfaces: access addresses in, lookup results out.
// Depends on sacl_pkg.
interface sacl_acc_if;
    logic                        valid;
    logic                        ready;
    logic [sacl_pkg::DATA_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface sacl_res_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [1:0]                  way_used;
    logic [sacl_pkg::DATA_W-1:0] access_count;
    logic [sacl_pkg::DATA_W-1:0] hit_count;
    logic [sacl_pkg::DATA_W-1:0] miss_count;

    modport source (output valid, output hit, output way_used, output access_count,
                    output hit_count, output miss_count, input ready);
    modport sink   (input valid, input hit, input way_used, input access_count,
                    input hit_count, input miss_count, output ready);
endinterface

>>> sv/sacl_cfg.sv
// APB-style configuration registers: base address, offset bits, set bits.
// Depends on sacl_pkg.
module sacl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0]   paddr,
    input  logic [sacl_pkg::DATA_W-1:0]    pwdata,
    output logic [sacl_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output sacl_pkg::t_cfg                 o_cfg
);
    import sacl_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= BASE_RST;
            r_cfg.offset_bits  <= OFS_RST;
            r_cfg.set_bits     <= SETB_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_BASE_ADDRESS: begin
                    r_cfg.base_address <= pwdata;
                end
                REG_OFFSET_BITS: begin
                    r_cfg.offset_bits <= pwdata[OFS_W-1:0];
                end
                REG_SET_BITS: begin
                    r_cfg.set_bits <= pwdata[SETB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_BASE_ADDRESS: prdata = r_cfg.base_address;
            REG_OFFSET_BITS:  prdata = DATA_W'(r_cfg.offset_bits);
            REG_SET_BITS:     prdata = DATA_W'(r_cfg.set_bits);
            default:          prdata = '0;
        endcase
    end

endmodule

>>> sv/set_assoc_cache_lru_model.sv
// Top level: set-associative cache tag store with age-counter LRU replacement.
// Depends on sacl_pkg, sacl_ifs (sacl_acc_if, sacl_res_if) and sacl_cfg.
//
//  Channel   Direction  Transaction carries
//  -------   ---------  ------------------------------------------------------
//  i_acc     in         address (32b) of one read access
//  o_res     out        hit, way_used, access_count, hit_count, miss_count
//  APB       in/out     base_address @0x0, offset_bits @0x4, set_bits @0x8
//
//  One access per cycle sustained while o_res.ready keeps the results
//  draining. The accept edge reads the set's tag and age rows from the
//  memories into stage 1; its advance compares, updates and writes back.
//  Back-to-back accesses to the same set see the row just written through
//  a one-entry bypass register. Valid bits and per-set "ages written" bits
//  are flip-flops cleared by reset, so no clearing pass is needed; an
//  unwritten age row reads as way 0 = 1, others 0. A stalled result holds
//  in the output register with the access behind it parked in stage 1.
module set_assoc_cache_lru_model #(
    parameter int unsigned WAYS      = sacl_pkg::WAYS_DEF,
    parameter int unsigned MAX_SETS  = sacl_pkg::MAX_SETS_DEF,
    parameter int unsigned AGE_WIDTH = sacl_pkg::AGE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sacl_acc_if.sink                     i_acc,
    sacl_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0] paddr,
    input  logic [sacl_pkg::DATA_W-1:0]  pwdata,
    output logic [sacl_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import sacl_pkg::*;

    localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned TAB_N  = 1 << SIDX_W;
    localparam int unsigned ROW_TW = WAYS * DATA_W;
    localparam int unsigned ROW_AW = WAYS * AGE_WIDTH;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX     = '1;
    localparam logic [ROW_AW-1:0]    AGE_ROW_RST = ROW_AW'(1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_cfg w_cfg;

    sacl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------------------------------------------------------
    // Address decode at accept time
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] w_rel;
    logic [DATA_W-1:0] w_blk_num;
    logic [DATA_W-1:0] w_blk_addr;
    logic [SIDX_W-1:0] w_set_mask;
    logic [SIDX_W-1:0] w_set_raw;
    logic [SET_W-1:0]  w_set_tab [TAB_N];
    logic [SET_W-1:0]  w_set_idx;

    assign w_rel      = i_acc.address - w_cfg.base_address;
    assign w_blk_num  = w_rel >> w_cfg.offset_bits;
    assign w_blk_addr = w_rel & (32'hFFFF_FFFF << w_cfg.offset_bits);
    assign w_set_mask = SIDX_W'((8'd1 << w_cfg.set_bits) - 8'd1);
    assign w_set_raw  = w_blk_num[SIDX_W-1:0] & w_set_mask;

    // Fold set indexes beyond the built set count back into range
    for (genvar g = 0; g < TAB_N; g++) begin : g_set_tab
        assign w_set_tab[g] = SET_W'(g % MAX_SETS);
    end
    assign w_set_idx = w_set_tab[w_set_raw];

    // ---------------------------------------------------------------
    // Handshake: stage 1 advances into the result register when it is
    // empty or being drained this cycle.
    // ---------------------------------------------------------------
    logic r_s1_v;
    logic r_out_v;
    logic w_s1_adv;
    logic w_acc_fire;

    assign w_s1_adv    = r_s1_v && (!r_out_v || o_res.ready);
    assign i_acc.ready = !r_s1_v || w_s1_adv;
    assign w_acc_fire  = i_acc.valid && i_acc.ready;

    // ---------------------------------------------------------------
    // Stage 1 registers and set storage
    // ---------------------------------------------------------------
    logic [SET_W-1:0]  r_s1_set;
    logic [DATA_W-1:0] r_s1_blk;

    logic [ROW_TW-1:0] r_tag_mem [MAX_SETS];
    logic [ROW_AW-1:0] r_age_mem [MAX_SETS];
    logic [ROW_TW-1:0] r_tag_rd;
    logic [ROW_AW-1:0] r_age_rd;

    logic [WAYS-1:0]     r_valid [MAX_SETS];
    logic [MAX_SETS-1:0] r_touched;

    // Last row written, for back-to-back same-set accesses
    logic              r_byp_v;
    logic [SET_W-1:0]  r_byp_set;
    logic [ROW_TW-1:0] r_byp_tags;
    logic [ROW_AW-1:0] r_byp_ages;

    logic              r_out_hit;
    logic [1:0]        r_out_way;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_hit;
    logic [DATA_W-1:0] r_miss;

    // ---------------------------------------------------------------
    // Stage 1 lookup, victim choice and age update
    // ---------------------------------------------------------------
    logic                 w_use_byp;
    logic [ROW_TW-1:0]    w_tag_row;
    logic [ROW_AW-1:0]    w_age_row;
    logic [WAYS-1:0]      w_vld_row;
    logic [WAYS-1:0]      w_match;
    logic                 w_hit;
    logic [WAY_W-1:0]     w_hit_way;
    logic [WAY_W-1:0]     w_vic_way;
    logic [AGE_WIDTH-1:0] w_vic_age;
    logic [WAY_W-1:0]     w_way;
    logic [ROW_TW-1:0]    n_tag_row;
    logic [ROW_AW-1:0]    n_age_row;
    logic [DATA_W-1:0]    n_acc;
    logic [DATA_W-1:0]    n_hit;
    logic [DATA_W-1:0]    n_miss;

    assign w_use_byp = r_byp_v && (r_byp_set == r_s1_set);
    assign w_tag_row = w_use_byp ? r_byp_tags : r_tag_rd;
    assign w_age_row = !r_touched[r_s1_set] ? AGE_ROW_RST
                     : (w_use_byp ? r_byp_ages : r_age_rd);
    assign w_vld_row = r_valid[r_s1_set];

    always_comb begin
        w_match = '0;
        for (int w = 0; w < WAYS; w++) begin
            w_match[w] = w_vld_row[w] && (w_tag_row[w*DATA_W +: DATA_W] == r_s1_blk);
        end
        w_hit = |w_match;

        // Lowest matching way wins
        w_hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                w_hit_way = WAY_W'(w);
            end
        end

        // Oldest way, lowest index on a tie, way 0 when all ages are zero
        w_vic_way = '0;
        w_vic_age = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (w_age_row[w*AGE_WIDTH +: AGE_WIDTH] > w_vic_age) begin
                w_vic_age = w_age_row[w*AGE_WIDTH +: AGE_WIDTH];
                w_vic_way = WAY_W'(w);
            end
        end

        w_way = w_hit ? w_hit_way : w_vic_way;

        n_tag_row = w_tag_row;
        n_age_row = w_age_row;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == w_way) begin
                n_age_row[w*AGE_WIDTH +: AGE_WIDTH] = '0;
                if (!w_hit) begin
                    n_tag_row[w*DATA_W +: DATA_W] = r_s1_blk;
                end
            end else if (w_age_row[w*AGE_WIDTH +: AGE_WIDTH] != AGE_MAX) begin
                n_age_row[w*AGE_WIDTH +: AGE_WIDTH] =
                    w_age_row[w*AGE_WIDTH +: AGE_WIDTH] + AGE_WIDTH'(1);
            end
        end

        n_acc  = r_acc + DATA_W'(1);
        n_hit  = w_hit ? r_hit + DATA_W'(1) : r_hit;
        n_miss = w_hit ? r_miss : r_miss + DATA_W'(1);
    end

    // ---------------------------------------------------------------
    // Tag and age memories: write back in stage 1, read at accept
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_tag_mem[r_s1_set] <= n_tag_row;
            r_age_mem[r_s1_set] <= n_age_row;
        end
        if (w_acc_fire) begin
            r_tag_rd <= r_tag_mem[w_set_idx];
            r_age_rd <= r_age_mem[w_set_idx];
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_byp_v   <= 1'b0;
            r_touched <= '0;
            r_acc     <= '0;
            r_hit     <= '0;
            r_miss    <= '0;
            for (int s = 0; s < MAX_SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            if (w_acc_fire) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_v <= 1'b0;
            end

            if (w_s1_adv) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end

            if (w_s1_adv) begin
                r_valid[r_s1_set][w_way] <= 1'b1;
                r_touched[r_s1_set]      <= 1'b1;
                r_byp_v                  <= 1'b1;
                r_acc                    <= n_acc;
                r_hit                    <= n_hit;
                r_miss                   <= n_miss;
            end
        end
    end

    // Payload: hold unless the stage advances
    always_ff @(posedge i_clk) begin
        if (w_acc_fire) begin
            r_s1_set <= w_set_idx;
            r_s1_blk <= w_blk_addr;
        end
        if (w_s1_adv) begin
            r_out_hit  <= w_hit;
            r_out_way  <= 2'(w_way);
            r_byp_set  <= r_s1_set;
            r_byp_tags <= n_tag_row;
            r_byp_ages <= n_age_row;
        end
    end

    // Counters only move when a result enters the output register, so they
    // always match the transaction on display.
    assign o_res.valid        = r_out_v;
    assign o_res.hit          = r_out_hit;
    assign o_res.way_used     = r_out_way;
    assign o_res.access_count = r_acc;
    assign o_res.hit_count    = r_hit;
    assign o_res.miss_count   = r_miss;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc == r_hit + r_miss)
        else $error("access count differs from hits plus misses");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> $onehot0(w_match))
        else $error("block address stored twice in one set");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_acc.ready |-> (r_s1_v && r_out_v && !o_res.ready))
        else $error("input stalled without a blocked result");

    a_row_touched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_touched[$past(r_s1_set)])
        else $error("written set not marked as holding ages");

    a_acc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> (r_acc == $past(r_acc) + DATA_W'(1)))
        else $error("access counter did not advance by one");

endmodule
